@@ rtl/core/bfp_pkg.sv @@
// ----------------------------------------------------------------------------
// bfp_pkg
// Shared types and constants of the bit field packer: item and result
// transactions, the normalized run held in the queue, and size limits.
// ----------------------------------------------------------------------------
package bfp_pkg;

  // Largest field accepted; longer fields saturate. Capped at the value width.
  localparam int MAX_FIELD_BITS = 32;
  localparam int VALUE_W        = 32;
  localparam int LEN_W          = 6;
  localparam int LEN_LIMIT      = (MAX_FIELD_BITS > VALUE_W) ? VALUE_W : MAX_FIELD_BITS;

  // Partial byte holds at most seven bits.
  localparam int ACC_W = 7;
  localparam int CNT_W = 3;

  // Working window of the back end: leftover bits plus one whole field.
  localparam int SR_W = ACC_W + VALUE_W;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Input transaction.
  typedef struct packed {
    logic [VALUE_W-1:0] field_value;
    logic [LEN_W-1:0]   field_length;
    logic               flush;
  } item_t;

  // Result transaction.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } result_t;

  // Field after normalization: stream order starts at bit 0.
  typedef struct packed {
    logic [VALUE_W-1:0] bits;
    logic [LEN_W-1:0]   len;
    logic               flush;
  } run_t;

  // Queue head handshake toward the back end.
  typedef struct packed {
    logic valid;
    run_t run;
  } head_t;

endpackage

@@ rtl/core/bfp_front.sv @@
// ----------------------------------------------------------------------------
// bfp_front
// Front end: saturates the field length and reverses the field so that the
// first stream bit sits in bit 0 and all bits above the length are zero.
// ----------------------------------------------------------------------------
module bfp_front
  import bfp_pkg::*;
(
  input  item_t item,
  output run_t  run
);

  logic [VALUE_W-1:0] rev;
  logic [LEN_W-1:0]   len_sat;
  logic [LEN_W-1:0]   shift;

  // Clamp length to the supported maximum
  always_comb begin
    if (item.field_length > LEN_W'(LEN_LIMIT)) begin
      len_sat = LEN_W'(LEN_LIMIT);
    end else begin
      len_sat = item.field_length;
    end
  end

  // Full-width bit reverse; MSB of the word lands in bit 0
  always_comb begin
    for (int k = 0; k < VALUE_W; k++) begin
      rev[k] = item.field_value[VALUE_W-1-k];
    end
  end

  // Drop the reversed bits that lie above the field
  assign shift = LEN_W'(VALUE_W) - len_sat;

  always_comb begin
    run.bits  = (len_sat == '0) ? '0 : (rev >> shift);
    run.len   = len_sat;
    run.flush = item.flush;
  end

endmodule

@@ rtl/core/bfp_queue.sv @@
// ----------------------------------------------------------------------------
// bfp_queue
// Short FIFO of normalized runs between front and back end, so each side
// can stall without holding the other.
// ----------------------------------------------------------------------------
module bfp_queue
  import bfp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  run_t  wr_run,
  output logic  full,
  input  logic  rd,
  output head_t head
);

  run_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.run   = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_run;
    end
  end

endmodule

@@ rtl/core/bfp_back.sv @@
// ----------------------------------------------------------------------------
// bfp_back
// Back end: merges each run with the pending partial byte, keeps the leftover
// bits and emits one packed byte per cycle while the result register is free.
// ----------------------------------------------------------------------------
module bfp_back
  import bfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  head_t   head,
  output logic    deq,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  // Pending partial byte
  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] cnt;

  // Run in progress
  logic             busy;
  logic [SR_W-1:0]  sr;
  logic [LEN_W-1:0] nb;
  logic             fl;

  // Result register
  logic             out_valid;

  logic [SR_W-1:0]  sr_load;
  logic [LEN_W-1:0] nb_load;
  logic [SR_W-1:0]  cur_sr;
  logic [LEN_W-1:0] cur_nb;
  logic             cur_fl;
  logic             active;
  logic             has_byte;
  logic             slot_free;
  logic [LEN_W-1:0] rem;
  logic [SR_W-1:0]  sr_shift;
  logic             more;
  logic             emit;
  logic             finish_quiet;

  assign empty = !out_valid;

  // Merge new run behind the pending bits
  assign sr_load = (SR_W'(head.run.bits) << cnt) | SR_W'(acc);
  assign nb_load = LEN_W'(cnt) + head.run.len;

  // Current view: run in progress or the one at the queue head
  always_comb begin
    active    = busy || head.valid;
    cur_sr    = busy ? sr : sr_load;
    cur_nb    = busy ? nb : nb_load;
    cur_fl    = busy ? fl : head.run.flush;
    has_byte  = (cur_nb >= LEN_W'(8)) || (cur_fl && (cur_nb != '0));
    slot_free = !out_valid || pop;
    rem       = (cur_nb >= LEN_W'(8)) ? (cur_nb - LEN_W'(8)) : '0;
    sr_shift  = cur_sr >> 8;
    more      = (rem >= LEN_W'(8)) || (cur_fl && (rem != '0));
    emit         = active && has_byte && slot_free;
    finish_quiet = active && !has_byte;
    deq          = !busy && head.valid && (emit || finish_quiet);
  end

  // Control and pending state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
      cnt       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        busy      <= more;
        if (!more) begin
          acc <= sr_shift[ACC_W-1:0];
          cnt <= rem[CNT_W-1:0];
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (finish_quiet) begin
        busy <= 1'b0;
        acc  <= cur_sr[ACC_W-1:0];
        cnt  <= cur_nb[CNT_W-1:0];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (emit) begin
      result.out_byte    <= cur_sr[7:0];
      result.last_of_run <= !more;
      sr <= sr_shift;
      nb <= rem;
      fl <= cur_fl;
    end
  end

  // A run in progress always has a byte left to send
  a_busy_has_byte: assert property (@(posedge clk) disable iff (rst)
    busy |-> ((nb >= LEN_W'(8)) || (fl && (nb != '0))))
    else $error("run in progress without a byte to send");

  // Unfilled positions of the partial byte stay zero
  a_acc_clean: assert property (@(posedge clk) disable iff (rst)
    (!busy) |-> ((acc >> cnt) == '0))
    else $error("partial byte has bits above its count");

  // The queue is drained only when no run is in progress
  a_deq_idle: assert property (@(posedge clk) disable iff (rst)
    deq |-> (!busy && head.valid))
    else $error("dequeue while a run is in progress");

  // Sending the final byte of a run frees the back end
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (emit && !more) |=> (!busy && out_valid && result.last_of_run))
    else $error("run not closed after its last byte");

endmodule

@@ rtl/core/bit_field_packer_top.sv @@
// ----------------------------------------------------------------------------
// bit_field_packer_top
// Bit stream writer: appends fields MSB first into bytes filled from bit 0.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (push/full, item): each transaction carries a value, a bit
//   count (above 32 saturates to 32) and a flush flag. Full is low while the
//   four-entry run queue has room.
//   Result channel (empty/pop, result): one packed byte per transaction, the
//   first stream bit in bit 0; last_of_run marks the final byte of an item.
//   A flush pads the pending partial byte with zeros and sends it; a flush
//   with nothing pending sends nothing. Items that complete no byte send none.
// Flow: an accepted item is written into the run queue; when the back end is
//   idle, its first byte then passes through the result register to the ports.
// Throughput: the back end sends one byte per cycle while pop keeps the
//   result register free and handles one item at a time; an item produces
//   at most five bytes. The byte-wide result register sets the rate.
// Stall: when pop stays low the result holds, the back end waits and the
//   queue fills; full then rises. Reset clears the queue, the pending bits
//   and the result register.
// ----------------------------------------------------------------------------
module bit_field_packer_top
  import bfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  run_t  front_run;
  head_t head;
  logic  deq;

  // Normalize incoming fields
  bfp_front u_front (
    .item (item),
    .run  (front_run)
  );

  // Decoupling queue
  bfp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (push && !full),
    .wr_run (front_run),
    .full   (full),
    .rd     (deq),
    .head   (head)
  );

  // Byte packing and result register
  bfp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .deq    (deq),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

endmodule

@@ test/bit_field_packer_top_test.sv @@
// ----------------------------------------------------------------------------
// bit_field_packer_top_test
// Self-checking bench for the bit field packer. A queue-fed driver offers
// field transactions, a packing predictor builds the expected byte stream at
// each accepted field, and a monitor compares every popped byte against it.
// Traffic runs a directed set of edge cases, then random fields under four
// handshake phases, with one long result hold-off to back up the input.
// ----------------------------------------------------------------------------
module bit_field_packer_top_test
  import bfp_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES   = 200;
  localparam int STALL_LIMIT   = 4000;
  localparam int TAIL_CYCLES   = 20;
  localparam int MAX_REPORTED  = 10;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    push = 1'b0;
  logic    full;
  item_t   item = '0;
  logic    empty;
  logic    pop = 1'b0;
  result_t result;

  // Fields waiting to be offered, and bytes the packer still owes us
  item_t   field_queue[$];
  result_t expected_bytes[$];

  // Predictor state: partial byte carried between fields
  logic [ACC_W-1:0] held_bits  = '0;
  logic [CNT_W-1:0] held_count = '0;

  // Handshake shaping: idle rates and the long result hold-off
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;

  // Bookkeeping
  int fields_accepted = 0;
  int bytes_checked   = 0;
  int flush_fields    = 0;
  int oversize_fields = 0;
  int mismatches      = 0;
  int stall_cycles    = 0;

  bit_field_packer_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #2 clk = ~clk;

  // Append one field to the predicted stream, MSB of the field first
  function automatic void pack_field(item_t f);
    int               len;
    logic [7:0]       acc;
    int               cnt;
    result_t          produced[$];
    result_t          r;
    acc = {1'b0, held_bits};
    cnt = held_count;
    len = f.field_length;
    if (len > LEN_LIMIT) begin
      len = LEN_LIMIT;
      oversize_fields++;
    end
    if (f.flush) flush_fields++;
    for (int i = len; i > 0; i--) begin
      acc[cnt] = f.field_value[i-1];
      cnt++;
      if (cnt == 8) begin
        r.out_byte    = acc;
        r.last_of_run = 1'b0;
        produced.push_back(r);
        acc = '0;
        cnt = 0;
      end
    end
    // flush sends the zero-padded partial byte, nothing if none pending
    if (f.flush && cnt > 0) begin
      r.out_byte    = acc;
      r.last_of_run = 1'b0;
      produced.push_back(r);
      acc = '0;
      cnt = 0;
    end
    if (produced.size() > 0) produced[produced.size()-1].last_of_run = 1'b1;
    foreach (produced[k]) expected_bytes.push_back(produced[k]);
    held_bits  = acc[ACC_W-1:0];
    held_count = cnt[CNT_W-1:0];
  endfunction

  // Driver: offer queued fields, hold each one until accepted
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        pack_field(item);
        fields_accepted++;
      end
      if (!push || !full) begin
        if (field_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          push <= 1'b1;
          item <= field_queue.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check popped bytes in order, then pick the next pop
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTED)
            $display("ERROR: unexpected byte %02h last %0b", result.out_byte,
                     result.last_of_run);
        end else begin
          result_t want;
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (result.out_byte !== want.out_byte ||
              result.last_of_run !== want.last_of_run) begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
              $display("ERROR: byte %0d expected %02h last %0b, got %02h last %0b",
                       bytes_checked, want.out_byte, want.last_of_run,
                       result.out_byte, result.last_of_run);
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: no transaction on either side for too long while work remains
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) ||
        (!push && field_queue.size() == 0 && expected_bytes.size() == 0)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TIMEOUT: no transaction for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic add_field(logic [VALUE_W-1:0] v, logic [LEN_W-1:0] l, logic f);
    item_t it;
    it.field_value  = v;
    it.field_length = l;
    it.flush        = f;
    field_queue.push_back(it);
  endtask

  // Wait until every field is taken and every byte has come back
  task automatic drain();
    while (field_queue.size() > 0 || push) @(negedge clk);
    while (expected_bytes.size() > 0) @(negedge clk);
  endtask

  task automatic run_phase(int s_pct, int r_pct, int count, bit long_hold);
    int          sel;
    logic [5:0]  len;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (long_hold) hold_req++;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 10)      len = 6'd0;
      else if (sel < 20) len = 6'($urandom_range(63, 33));
      else if (sel < 35) len = 6'd32;
      else               len = 6'($urandom_range(31, 1));
      add_field($urandom, len, ($urandom_range(3) == 0));
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty flush, zero length, byte boundaries, saturation
    add_field(32'h0000_0000, 6'd0,  1'b1);
    add_field(32'hFFFF_FFFF, 6'd0,  1'b0);
    add_field(32'h0000_0001, 6'd1,  1'b0);
    add_field(32'h0000_0000, 6'd0,  1'b1);
    add_field(32'h0000_00A5, 6'd8,  1'b0);
    add_field(32'hFFFF_FFFF, 6'd7,  1'b0);
    add_field(32'h0000_0001, 6'd1,  1'b0);
    add_field(32'h0000_01FF, 6'd9,  1'b1);
    add_field(32'h0000_0000, 6'd0,  1'b1);
    add_field(32'hFFFF_FFFF, 6'd32, 1'b0);
    add_field(32'h0000_0000, 6'd32, 1'b0);
    add_field(32'hAAAA_AAAA, 6'd32, 1'b1);
    add_field(32'h5555_5555, 6'd31, 1'b1);
    add_field(32'hFFFF_FFFF, 6'd63, 1'b0);
    add_field(32'h8000_0001, 6'd33, 1'b1);
    add_field(32'h0000_0003, 6'd3,  1'b0);
    add_field(32'hDEAD_BEEF, 6'd32, 1'b1);
    add_field(32'h0000_0001, 6'd7,  1'b0);
    add_field(32'hFFFF_FFFF, 6'd63, 1'b1);
    add_field(32'h1234_5678, 6'd16, 1'b0);
    add_field(32'h0000_0000, 6'd0,  1'b1);
    drain();

    // Random: free flow with a long result hold-off, then idling phases
    run_phase(0,  0,  100, 1'b1);
    run_phase(81, 0,  100, 1'b0);
    run_phase(0,  81, 100, 1'b0);
    run_phase(27, 27, 100, 1'b0);

    repeat (TAIL_CYCLES) @(negedge clk);
    $display("Checked %0d fields (%0d flushing, %0d oversized) and %0d bytes",
             fields_accepted, flush_fields, oversize_fields, bytes_checked);
    $display("Phases: free flow with long hold-off, sender idle, receiver stall, both");
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Mismatches: %0d, bytes still owed: %0d", mismatches,
               expected_bytes.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bfp_pkg.sv
rtl/core/bfp_front.sv
rtl/core/bfp_queue.sv
rtl/core/bfp_back.sv
rtl/core/bit_field_packer_top.sv
test/bit_field_packer_top_test.sv
